@@ src/crt_phosphor_scanline_upscaler_assert.svh @@
// Assertion macros for the scanline upscaler.
`ifndef CRT_PHOSPHOR_SCANLINE_UPSCALER_ASSERT_SVH
`define CRT_PHOSPHOR_SCANLINE_UPSCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPSU_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPSU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CPSU_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CPSU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/cpsu_pkg.sv @@
package cpsu_pkg;

    localparam int COEF_FRAC_BITS = 12;
    localparam int CW = COEF_FRAC_BITS + 1;

    typedef logic [23:0] pixel_t;
    typedef logic [CW-1:0] coef_t;
    typedef logic [255:0][CW-1:0] tab8_t;
    typedef logic [63:0][CW-1:0] tab6_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_A,
        ST_COL_B,
        ST_COL_C,
        ST_WAIT
    } state_t;

    typedef enum logic [1:0] {
        COL_ODD = 2'd0,
        COL_EVEN = 2'd1,
        COL_LAST = 2'd2,
        COL_FIRST = 2'd3
    } col_t;

    typedef struct packed {
        logic load;
        logic emit;
        col_t col;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic eol;
    } stat_t;

    // Largest t with t^11 * m^5 <= i^5 * 2^330, found bit by bit with exact integers.
    function automatic logic [30:0] root_q30(input int i, input int m);
        logic [399:0] target;
        logic [399:0] m5;
        logic [399:0] acc;
        logic [30:0] t;
        logic [30:0] cand;
        t = '0;
        m5 = 400'(m) * 400'(m) * 400'(m) * 400'(m) * 400'(m);
        target = (400'(i) * 400'(i) * 400'(i) * 400'(i) * 400'(i)) << 330;
        for (int bitn = 30; bitn >= 0; bitn--)
        begin
            cand = t | (31'd1 << bitn);
            acc = m5;
            for (int n = 0; n < 11; n++)
                acc = acc * 400'(cand);
            if (acc <= target)
                t = cand;
        end
        return t;
    endfunction

    // Floor quotients are found by a restoring search on multiplies only.
    function automatic coef_t coef_k(input int i, input int m);
        logic [79:0] num;
        coef_t q;
        num = ((80'd780 << 30) + 80'd624 * 80'(root_q30(i, m))) << COEF_FRAC_BITS;
        num = num + (80'd500 << 30);
        q = '0;
        for (int bitn = CW - 1; bitn >= 0; bitn--)
        begin
            q[bitn] = 1'b1;
            if (80'(q) * (80'd1000 << 30) > num)
                q[bitn] = 1'b0;
        end
        return q;
    endfunction

    function automatic coef_t coef_s(input int i, input int m);
        logic [79:0] num;
        logic [79:0] den;
        coef_t q;
        num = (80'(10 * m + 3 * i) << COEF_FRAC_BITS) + 80'(10 * m);
        den = 80'(20 * m);
        q = '0;
        for (int bitn = CW - 1; bitn >= 0; bitn--)
        begin
            q[bitn] = 1'b1;
            if (80'(q) * den > num)
                q[bitn] = 1'b0;
        end
        return q;
    endfunction

    function automatic tab8_t build_k8();
        tab8_t t;
        for (int i = 0; i < 256; i++)
            t[i] = coef_k(i, 255);
        return t;
    endfunction

    function automatic tab8_t build_s8();
        tab8_t t;
        for (int i = 0; i < 256; i++)
            t[i] = coef_s(i, 255);
        return t;
    endfunction

    function automatic tab6_t build_k6();
        tab6_t t;
        for (int i = 0; i < 64; i++)
            t[i] = coef_k(i, 31);
        return t;
    endfunction

    function automatic tab6_t build_s6();
        tab6_t t;
        for (int i = 0; i < 64; i++)
            t[i] = coef_s(i, 31);
        return t;
    endfunction

    localparam tab8_t K8_TAB = build_k8();
    localparam tab8_t S8_TAB = build_s8();
    localparam tab6_t K6_TAB = build_k6();
    localparam tab6_t S6_TAB = build_s6();

    function automatic coef_t k_lookup(input logic fmt, input logic [7:0] v);
        return fmt ? K6_TAB[v[5:0]] : K8_TAB[v];
    endfunction

    function automatic coef_t s_lookup(input logic fmt, input logic [7:0] v);
        return fmt ? S6_TAB[v[5:0]] : S8_TAB[v];
    endfunction

endpackage

@@ src/cpsu_pix_if.sv @@
interface cpsu_pix_if;
    logic valid;
    logic ready;
    logic [23:0] src_pixel;
    logic end_of_line;
    modport source (output valid, output src_pixel, output end_of_line, input ready);
    modport sink (input valid, input src_pixel, input end_of_line, output ready);
endinterface

@@ src/cpsu_col_if.sv @@
interface cpsu_col_if;
    logic valid;
    logic ready;
    logic [23:0] top_pixel;
    logic [23:0] bottom_pixel;
    logic line_done;
    modport source (output valid, output top_pixel, output bottom_pixel, output line_done,
        input ready);
    modport sink (input valid, input top_pixel, input bottom_pixel, input line_done,
        output ready);
endinterface

@@ src/cpsu_cfg_if.sv @@
interface cpsu_cfg_if;
    logic valid;
    logic ready;
    logic pixel_format;
    modport source (output valid, output pixel_format, input ready);
    modport sink (input valid, input pixel_format, output ready);
endinterface

@@ src/cpsu_ctrl.sv @@
module cpsu_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cpsu_pkg::stat_t stat,
    output cpsu_pkg::cmd_t cmd
);
    import cpsu_pkg::*;

    state_t state_reg, state_next;
    logic start_reg, start_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_COL_A;
                end
            end
            ST_COL_A:
            begin
                if (!stat.out_busy)
                begin
                    if (start_reg && !stat.eol)
                    begin
                        state_next = ST_IDLE;
                        start_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_COL_B;
                    end
                end
            end
            ST_COL_B:
            begin
                if (!stat.out_busy)
                begin
                    if (!start_reg && stat.eol)
                    begin
                        state_next = ST_COL_C;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        start_next = stat.eol;
                    end
                end
            end
            ST_COL_C:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                    start_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cmd.load = in_ready && in_valid;
        cmd.emit = 1'b0;
        cmd.col = COL_ODD;
        case (state_reg)
            ST_COL_A:
            begin
                cmd.emit = !stat.out_busy;
                cmd.col = start_reg ? COL_FIRST : COL_ODD;
            end
            ST_COL_B:
            begin
                cmd.emit = !stat.out_busy;
                cmd.col = start_reg ? COL_LAST : COL_EVEN;
            end
            ST_COL_C:
            begin
                cmd.emit = !stat.out_busy;
                cmd.col = COL_LAST;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

@@ src/cpsu_datapath.sv @@
module cpsu_datapath (
    input  logic clk,
    input  logic rst_n,
    input  logic fmt,
    input  cpsu_pkg::cmd_t cmd,
    input  logic [23:0] src_pixel,
    input  logic end_of_line,
    output cpsu_pkg::stat_t stat,
    output logic out_valid,
    input  logic out_ready,
    output logic [23:0] top_pixel,
    output logic [23:0] bottom_pixel,
    output logic line_done
);
    import cpsu_pkg::*;

    pixel_t held_reg, cur_reg;
    logic first_reg, eol_reg, started_reg;
    logic ov_reg;
    pixel_t top_reg;
    logic done_reg;
    logic tv_reg;
    logic [23:0] bot_reg;
    logic [23:0] top_out_reg;
    logic done_out_reg;

    function automatic pixel_t blend(input logic f, input pixel_t a, input pixel_t b);
        logic [15:0] x;
        if (f)
        begin
            x = ({1'b0, a[15:1]} & 16'h7BEF) + ({1'b0, b[15:1]} & 16'h7BEF);
            return {8'd0, x};
        end
        return ((a >> 1) & 24'h7f7f7f) + ((b >> 1) & 24'h7f7f7f);
    endfunction

    function automatic logic [7:0] chan(input logic f, input pixel_t p, input int c);
        if (f)
        begin
            case (c)
                0: return {2'b0, p[15:11], 1'b0};
                1: return {2'b0, p[10:5]};
                default: return {2'b0, p[4:0], 1'b0};
            endcase
        end
        case (c)
            0: return p[23:16];
            1: return p[15:8];
            default: return p[7:0];
        endcase
    endfunction

    function automatic logic [7:0] clampc(input logic f, input logic [CW+8:0] v);
        logic [CW+8:0] m;
        m = f ? (CW+9)'(63) : (CW+9)'(255);
        return (v > m) ? m[7:0] : v[7:0];
    endfunction

    function automatic logic [7:0] bleed(input logic f, input logic [7:0] v);
        logic [CW+8:0] pr;
        pr = (CW+9)'(v) * (CW+9)'(k_lookup(f, v));
        return clampc(f, pr >> COEF_FRAC_BITS);
    endfunction

    function automatic pixel_t pack(input logic f, input logic [7:0] r, input logic [7:0] g,
        input logic [7:0] b);
        if (f) return {8'd0, r[5:1], g[5:0], b[5:1]};
        return {r, g, b};
    endfunction

    pixel_t pcur, e_pix, o_pix, l_pix, b0;
    logic [7:0] r, g, b, gb;
    logic [CW+8:0] gprod;

    always_comb
    begin
        pcur = fmt ? {8'd0, cur_reg[15:0]} : cur_reg;
        e_pix = first_reg ? blend(fmt, held_reg, 24'd0) : held_reg;
        o_pix = blend(fmt, held_reg, pcur);
        l_pix = blend(fmt, pcur, 24'd0);
        b0 = l_pix;
        case (cmd.col)
            COL_FIRST:
            begin
                r = chan(fmt, b0, 0);
                g = chan(fmt, b0, 1);
                b = 8'd0;
            end
            COL_ODD:
            begin
                r = bleed(fmt, chan(fmt, e_pix, 0));
                g = chan(fmt, o_pix, 1);
                b = chan(fmt, o_pix, 2);
            end
            COL_EVEN:
            begin
                r = chan(fmt, pcur, 0);
                g = chan(fmt, pcur, 1);
                b = bleed(fmt, chan(fmt, o_pix, 2));
            end
            default:
            begin
                r = bleed(fmt, chan(fmt, started_reg ? b0 : pcur, 0));
                g = chan(fmt, l_pix, 1);
                b = chan(fmt, l_pix, 2);
            end
        endcase
        gprod = (CW+9)'(g) * (CW+9)'(k_lookup(fmt, g));
        gb = clampc(fmt, (CW+9)'(g >> 1) + (gprod >> (COEF_FRAC_BITS + 1)));
    end

    // Stage two: bottom line scale from the registered top pixel.
    logic [7:0] tr, tg, tb, mx;
    coef_t s;
    logic [CW+7:0] pr_r, pr_g, pr_b;

    always_comb
    begin
        tr = chan(fmt, top_reg, 0);
        tg = chan(fmt, top_reg, 1);
        tb = chan(fmt, top_reg, 2);
        mx = tr;
        if (tg > mx) mx = tg;
        if (tb > mx) mx = tb;
        s = s_lookup(fmt, mx);
        pr_r = (CW+8)'(s) * (CW+8)'(tr);
        pr_g = (CW+8)'(s) * (CW+8)'(tg);
        pr_b = (CW+8)'(s) * (CW+8)'(tb);
    end

    logic adv;
    assign adv = ov_reg && !out_ready ? 1'b0 : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            cur_reg <= '0;
            first_reg <= 1'b0;
            eol_reg <= 1'b0;
            started_reg <= 1'b0;
            tv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cur_reg <= src_pixel;
                eol_reg <= end_of_line;
                started_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                if (cmd.col == COL_FIRST) started_reg <= 1'b1;
                if (cmd.col == COL_FIRST && !eol_reg)
                begin
                    held_reg <= pcur;
                    first_reg <= 1'b1;
                end
                else if (cmd.col == COL_EVEN && !eol_reg)
                begin
                    held_reg <= pcur;
                    first_reg <= 1'b0;
                end
                else if (cmd.col == COL_LAST)
                begin
                    held_reg <= pcur;
                    first_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                tv_reg <= cmd.emit;
                ov_reg <= tv_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            top_reg <= pack(fmt, r, gb, b);
            done_reg <= cmd.emit && cmd.col == COL_LAST;
            top_out_reg <= top_reg;
            done_out_reg <= done_reg;
            bot_reg <= pack(fmt, pr_r[COEF_FRAC_BITS +: 8], pr_g[COEF_FRAC_BITS +: 8],
                pr_b[COEF_FRAC_BITS +: 8]);
        end
    end

    assign top_pixel = top_out_reg;
    assign line_done = done_out_reg;
    assign bottom_pixel = bot_reg;
    assign out_valid = ov_reg;
    assign stat.out_busy = !adv;
    assign stat.eol = eol_reg;

endmodule

@@ src/crt_phosphor_scanline_upscaler.sv @@
// Channel | Direction | Payload
// pix     | in        | src_pixel, end_of_line
// col     | out       | top_pixel, bottom_pixel, line_done
// cfg     | in        | pixel_format
// A source pixel is taken in the idle state, then yields one output column per sequencer state (1 to 3).
// Columns pass a two-stage pipeline: top pixel, then the scanline scale.
// An output stall holds the column sequencer until the last stage frees.
// Reset clears the line state; the format register resets to rgb888.
module crt_phosphor_scanline_upscaler (
    input logic clk,
    input logic rst_n,
    cpsu_pix_if.sink pix,
    cpsu_col_if.source col,
    cpsu_cfg_if.sink cfg
);
    import cpsu_pkg::*;
    `include "crt_phosphor_scanline_upscaler_assert.svh"

    logic fmt_reg;
    cmd_t cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            fmt_reg <= cfg.pixel_format;
        end
    end

    assign cfg.ready = 1'b1;

    cpsu_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(pix.valid),
        .in_ready(pix.ready),
        .stat(stat),
        .cmd(cmd)
    );

    cpsu_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .fmt(fmt_reg),
        .cmd(cmd),
        .src_pixel(pix.src_pixel),
        .end_of_line(pix.end_of_line),
        .stat(stat),
        .out_valid(col.valid),
        .out_ready(col.ready),
        .top_pixel(col.top_pixel),
        .bottom_pixel(col.bottom_pixel),
        .line_done(col.line_done)
    );

    `CPSU_ASSERT_IMPL(a_load_not_emit, clk, rst_n, !(cmd.load && cmd.emit), "load during emit")
    `CPSU_ASSERT_NEXT(a_stall_hold, clk, rst_n, col.valid && !col.ready, col.valid,
        "column dropped")
    `CPSU_ASSERT_IMPL(a_rgb565_top, clk, rst_n,
        !(col.valid && fmt_reg) || col.top_pixel[23:16] == 8'd0, "top pixel packing")

endmodule
